@@ hdl/ial_pkg.sv @@
// ----------------------------------------------------------------------------
// ial_pkg: shared types and constants of the integer ALU
// Item structs, command codes and the lane record that moves down the chain.
// ----------------------------------------------------------------------------
package ial_pkg;

    localparam int XLEN  = 64;
    localparam int WLEN  = 32;
    localparam int WTOP  = 31;
    localparam int STEPS = 64;

    typedef enum logic [4:0] {
        CMD_LSL     = 5'd0,
        CMD_LSR     = 5'd1,
        CMD_ASR     = 5'd2,
        CMD_ROR     = 5'd3,
        CMD_RRX     = 5'd4,
        CMD_ADD     = 5'd5,
        CMD_SUB     = 5'd6,
        CMD_MUL     = 5'd7,
        CMD_UMULH   = 5'd8,
        CMD_SMULH   = 5'd9,
        CMD_UDIV    = 5'd10,
        CMD_SDIV    = 5'd11,
        CMD_AND     = 5'd12,
        CMD_OR      = 5'd13,
        CMD_EOR     = 5'd14,
        CMD_NOT     = 5'd15,
        CMD_CLZ     = 5'd16,
        CMD_REV     = 5'd17,
        CMD_EXTRACT = 5'd18,
        CMD_SMAX    = 5'd19,
        CMD_UMAX    = 5'd20,
        CMD_SMIN    = 5'd21,
        CMD_UMIN    = 5'd22,
        CMD_SXTB    = 5'd23,
        CMD_SXTH    = 5'd24,
        CMD_SXTW    = 5'd25,
        CMD_TESTBIT = 5'd26
    } cmd_t;

    typedef struct packed {
        logic [4:0]      command;
        logic            double_width;
        logic [XLEN-1:0] operand_a;
        logic [XLEN-1:0] operand_b;
        logic [7:0]      shift_amount;
        logic            carry_flag_in;
    } req_t;

    typedef struct packed {
        logic [XLEN-1:0] result_value;
        logic            negative_flag;
        logic            zero_flag;
        logic            carry_flag_out;
        logic            overflow_flag;
    } rsp_t;

    // Everything one item carries from cell to cell
    typedef struct packed {
        logic [4:0]      cmd;
        logic            wide;
        logic [XLEN-1:0] simple_res;
        logic            simple_c;
        logic            simple_v;
        logic [XLEN-1:0] mul_hi;
        logic [XLEN-1:0] mul_lo;
        logic [XLEN-1:0] mul_b;
        logic [XLEN-1:0] mul_corr;
        logic [XLEN-1:0] div_rem;
        logic [XLEN-1:0] div_q;
        logic [XLEN-1:0] div_d;
        logic            div_neg;
        logic            div_zero;
    } lane_t;

endpackage

@@ hdl/ial_front.sv @@
// ----------------------------------------------------------------------------
// ial_front: decode stage
// Computes the operations that need no chain and seeds multiply and divide lanes.
// ----------------------------------------------------------------------------
module ial_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          up_valid,
    input  ial_pkg::req_t up,
    output logic          dn_valid,
    output ial_pkg::lane_t dn
);
    import ial_pkg::*;

    logic   valid_reg;
    lane_t  lane_reg;
    lane_t  lane_next;

    always_comb
    begin
        logic            wide;
        logic [63:0]     m;
        logic [63:0]     sb;
        logic [63:0]     a;
        logic [63:0]     b;
        logic [63:0]     bb;
        logic [63:0]     r;
        logic [63:0]     sx;
        logic [63:0]     rev64;
        logic [63:0]     rev32;
        logic [127:0]    dbl;
        logic [127:0]    cat;
        logic [64:0]     sum;
        logic [6:0]      w;
        logic [7:0]      wn;
        logic [7:0]      n;
        logic [6:0]      idx;
        logic [6:0]      cnt;
        logic [5:0]      k;
        logic            c;
        logic            v;
        logic            na;
        logic            nb;
        logic            cin;

        wide = up.double_width;
        m    = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        sb   = wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        w    = wide ? 7'(XLEN) : 7'(WLEN);
        wn   = {1'b0, w};
        a    = up.operand_a & m;
        b    = up.operand_b & m;
        n    = up.shift_amount;
        cin  = up.carry_flag_in;
        na   = |(a & sb);
        nb   = |(b & sb);
        sx   = wide ? a : {{32{a[31]}}, a[31:0]};
        bb   = (cmd_t'(up.command) == CMD_SUB) ? (~b & m) : b;
        sum  = {1'b0, a} + {1'b0, bb} + 65'(cin);
        k    = wide ? n[5:0] : {1'b0, n[4:0]};
        dbl  = wide ? {a, a} : {64'b0, a[31:0], a[31:0]};
        cat  = wide ? {b, a} : {64'b0, b[31:0], a[31:0]};
        idx  = 7'd0;
        r    = '0;
        c    = 1'b0;
        v    = 1'b0;

        // Highest set bit wins
        cnt = w;
        for (int i = 0; i < XLEN; i++)
        begin
            if (a[i])
                cnt = 7'(w - 7'd1 - 7'(i));
        end

        rev64 = '0;
        for (int i = 0; i < 8; i++)
            rev64[8*i +: 8] = a[8*(7-i) +: 8];
        rev32 = '0;
        for (int i = 0; i < 4; i++)
            rev32[8*i +: 8] = a[8*(3-i) +: 8];

        unique case (cmd_t'(up.command))
            CMD_LSL:
            begin
                if (n == 8'd0)
                begin
                    r = a;
                    c = cin;
                end
                else if (n <= wn)
                begin
                    idx = w - n[6:0];
                    r   = (n < wn) ? ((a << n[5:0]) & m) : '0;
                    c   = a[idx[5:0]];
                end
            end
            CMD_LSR:
            begin
                if (n == 8'd0)
                begin
                    r = a;
                    c = cin;
                end
                else if (n <= wn)
                begin
                    idx = n[6:0] - 7'd1;
                    r   = (n < wn) ? (a >> n[5:0]) : '0;
                    c   = a[idx[5:0]];
                end
            end
            CMD_ASR:
            begin
                if (n == 8'd0)
                begin
                    r = a;
                    c = cin;
                end
                else if (n < wn)
                begin
                    idx = n[6:0] - 7'd1;
                    r   = 64'($signed(sx) >>> n[5:0]) & m;
                    c   = a[idx[5:0]];
                end
                else
                begin
                    r = na ? m : '0;
                    c = na;
                end
            end
            CMD_ROR:
            begin
                if (n == 8'd0)
                begin
                    r = a;
                    c = cin;
                end
                else
                begin
                    r = 64'(dbl >> k) & m;
                    c = |(r & sb);
                end
            end
            CMD_RRX:
            begin
                r = (a >> 1) | (cin ? sb : 64'd0);
                c = a[0];
            end
            CMD_ADD, CMD_SUB:
            begin
                r = sum[63:0] & m;
                c = wide ? sum[64] : sum[32];
                v = |((a ^ r) & (bb ^ r) & sb);
            end
            CMD_MUL, CMD_UMULH, CMD_SMULH, CMD_UDIV, CMD_SDIV: r = '0;
            CMD_AND:     r = a & b;
            CMD_OR:      r = a | b;
            CMD_EOR:     r = a ^ b;
            CMD_NOT:     r = ~a & m;
            CMD_CLZ:     r = 64'(cnt);
            CMD_REV:     r = wide ? rev64 : rev32;
            CMD_EXTRACT: r = (n < {w, 1'b0}) ? (64'(cat >> n) & m) : '0;
            CMD_SMAX:    r = ((a ^ sb) > (b ^ sb)) ? a : b;
            CMD_UMAX:    r = (a > b) ? a : b;
            CMD_SMIN:    r = ((a ^ sb) < (b ^ sb)) ? a : b;
            CMD_UMIN:    r = (a < b) ? a : b;
            CMD_SXTB:    r = {{56{a[7]}}, a[7:0]} & m;
            CMD_SXTH:    r = {{48{a[15]}}, a[15:0]} & m;
            CMD_SXTW:    r = {{32{a[31]}}, a[31:0]} & m;
            CMD_TESTBIT: r = (n < wn) ? 64'(a[n[5:0]]) : '0;
            default:     r = '0;
        endcase

        lane_next.cmd        = up.command;
        lane_next.wide       = wide;
        lane_next.simple_res = r;
        lane_next.simple_c   = c;
        lane_next.simple_v   = v;
        lane_next.mul_hi     = '0;
        lane_next.mul_lo     = a;
        lane_next.mul_b      = b;
        lane_next.mul_corr   = (na ? b : 64'd0) + (nb ? a : 64'd0);
        lane_next.div_rem    = '0;
        lane_next.div_zero   = (b == 64'd0);
        if (cmd_t'(up.command) == CMD_SDIV)
        begin
            lane_next.div_q   = na ? ((64'd0 - a) & m) : a;
            lane_next.div_d   = nb ? ((64'd0 - b) & m) : b;
            lane_next.div_neg = na ^ nb;
        end
        else
        begin
            lane_next.div_q   = a;
            lane_next.div_d   = b;
            lane_next.div_neg = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            lane_reg <= lane_next;
    end

    assign dn_valid = valid_reg;
    assign dn       = lane_reg;

endmodule

@@ hdl/ial_cell.sv @@
// ----------------------------------------------------------------------------
// ial_cell: one step of the arithmetic chain
// Adds one multiplier bit and develops one quotient bit per item.
// ----------------------------------------------------------------------------
module ial_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           up_valid,
    input  ial_pkg::lane_t up,
    output logic           dn_valid,
    output ial_pkg::lane_t dn
);
    import ial_pkg::*;

    logic   valid_reg;
    lane_t  lane_reg;
    lane_t  lane_next;
    logic [64:0] acc;
    logic [64:0] shifted;
    logic [65:0] diff;

    always_comb
    begin
        lane_next = up;

        // Multiply: add b when the low multiplier bit is set, shift right
        acc = {1'b0, up.mul_hi} + (up.mul_lo[0] ? {1'b0, up.mul_b} : 65'd0);
        lane_next.mul_hi = acc[64:1];
        lane_next.mul_lo = {acc[0], up.mul_lo[63:1]};

        // Divide: restoring step, quotient bit shifts in at the bottom
        shifted = {up.div_rem, up.div_q[63]};
        diff    = {1'b0, shifted} - {2'b0, up.div_d};
        if (!diff[65])
        begin
            lane_next.div_rem = diff[63:0];
            lane_next.div_q   = {up.div_q[62:0], 1'b1};
        end
        else
        begin
            lane_next.div_rem = shifted[63:0];
            lane_next.div_q   = {up.div_q[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            lane_reg <= lane_next;
    end

    assign dn_valid = valid_reg;
    assign dn       = lane_reg;

endmodule

@@ hdl/ial_back.sv @@
// ----------------------------------------------------------------------------
// ial_back: result select and flags
// Finishes multiply and divide, picks the result and forms NZCV.
// ----------------------------------------------------------------------------
module ial_back (
    input  ial_pkg::lane_t lane,
    output ial_pkg::rsp_t  rsp
);
    import ial_pkg::*;

    always_comb
    begin
        logic [63:0] m;
        logic [63:0] sb;
        logic [63:0] high;
        logic [63:0] quo;
        logic [63:0] r;
        logic        known;

        m    = lane.wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
        sb   = lane.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        high = lane.wide ? lane.mul_hi : {32'b0, lane.mul_lo[63:32]};
        quo  = lane.div_neg ? (64'd0 - lane.div_q) : lane.div_q;

        case (cmd_t'(lane.cmd))
            CMD_MUL:             r = lane.mul_lo & m;
            CMD_UMULH:           r = high;
            CMD_SMULH:           r = (high - lane.mul_corr) & m;
            CMD_UDIV, CMD_SDIV:  r = lane.div_zero ? 64'd0 : (quo & m);
            default:             r = lane.simple_res;
        endcase

        known = (lane.cmd <= CMD_TESTBIT);

        rsp.result_value   = r;
        rsp.negative_flag  = known && (cmd_t'(lane.cmd) != CMD_TESTBIT) && (|(r & sb));
        rsp.zero_flag      = known && (r == 64'd0);
        rsp.carry_flag_out = lane.simple_c;
        rsp.overflow_flag  = lane.simple_v;
    end

endmodule

@@ hdl/integer_alu_with_flags.sv @@
// ----------------------------------------------------------------------------
// integer_alu_with_flags: 32/64-bit integer ALU with NZCV flags
// Shifts, add/sub, multiply, divide, logic and bit operations in a pipeline.
// ----------------------------------------------------------------------------
// The block takes one item per cycle unless stalled and returns one result
// item per item, in order, passing through one decode stage, a chain of 64
// identical cells and the output register. Each cell retires one multiplier
// bit and one quotient bit, so the chain length is set by the 64-bit
// operand width of multiply and divide; all other commands finish in the
// decode stage and ride the chain unchanged. The whole chain advances
// together whenever the output register is empty or being taken, so a
// stall on the result side holds every item in place and stalls the request
// side in the same cycle. Division by zero returns zero and the most
// negative value divided by minus one returns itself.
// ----------------------------------------------------------------------------
module integer_alu_with_flags (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ial_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ial_pkg::rsp_t rsp
);
    import ial_pkg::*;

    // Chain taps: index 0 is the decode stage, i+1 is the output of cell i
    logic  [STEPS:0] pipe_valid;
    lane_t           pipe_lane [0:STEPS];

    logic  advance;
    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;

    // Move everything one step when the output slot is free or being taken
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !advance;

    ial_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .up_valid (req_valid),
        .up       (req),
        .dn_valid (pipe_valid[0]),
        .dn       (pipe_lane[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        ial_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .up_valid (pipe_valid[i]),
            .up       (pipe_lane[i]),
            .dn_valid (pipe_valid[i+1]),
            .dn       (pipe_lane[i+1])
        );
    end

    // Finish multiply and divide, then form the flags
    ial_back u_back (
        .lane (pipe_lane[STEPS]),
        .rsp  (rsp_next)
    );

    // Output register: hold while stalled, refill as the chain advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= pipe_valid[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled while output slot is empty");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(pipe_valid))
        else $error("chain moved while result was stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> pipe_valid[0])
        else $error("accepted item missing from decode stage");
`endif

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the integer ALU with NZCV flags
// Drives directed corner items and weighted random items through the ALU with
// random idle bursts on both sides, and checks every result against a local
// bit-exact ALU model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;

    import ial_pkg::*;

    localparam int LATENCY  = 66;
    localparam int WDOG_MAX = 4000;
    localparam int N_RANDOM = 1230;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    int    err_count;
    int    wdog;
    int    n_sent;
    int    n_checked;
    bit    quiet_phase;   // no idling on either side near the end

    integer_alu_with_flags DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Print one mismatch line and count it
    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h (item %0d)", what, got, want, n_checked);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the ALU result of each accepted item and keeps the
    // predictions in order until the matching result item comes out.
    // ------------------------------------------------------------------------
    class alu_scoreboard;
        rsp_t pending[$];

        // Unsigned high half of a 64x64 product
        function automatic logic [63:0] umul_hi(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[127:64];
        endfunction

        function automatic rsp_t compute_alu(req_t r);
            rsp_t          o;
            logic          wide;
            int            w;
            logic [63:0]   m, sb, a, b, res, bb, q, ma, mb, sa, sbv;
            logic [64:0]   sum;
            int            n, k, cnt;
            logic          c, v, nz_ok, tbit;
            wide  = r.double_width;
            w     = wide ? 64 : 32;
            m     = wide ? '1 : 64'h0000_0000_FFFF_FFFF;
            sb    = 64'd1 << (w - 1);
            a     = r.operand_a & m;
            b     = r.operand_b & m;
            n     = int'(r.shift_amount);
            res   = '0;
            c     = 1'b0;
            v     = 1'b0;
            nz_ok = 1'b1;
            tbit  = 1'b0;
            case (r.command)
                CMD_LSL:
                    if (n == 0) begin res = a; c = r.carry_flag_in; end
                    else if (n < w) begin res = (a << n) & m; c = a[w - n]; end
                    else if (n == w) begin res = '0; c = a[0]; end
                CMD_LSR:
                    if (n == 0) begin res = a; c = r.carry_flag_in; end
                    else if (n < w) begin res = a >> n; c = a[n - 1]; end
                    else if (n == w) begin res = '0; c = a[w - 1]; end
                CMD_ASR:
                    if (n == 0) begin res = a; c = r.carry_flag_in; end
                    else if (n < w)
                    begin
                        res = a >> n;
                        if (a[w - 1]) res = res | (m & ~(m >> n));
                        c = a[n - 1];
                    end
                    else begin res = a[w - 1] ? m : '0; c = a[w - 1]; end
                CMD_ROR:
                    if (n == 0) begin res = a; c = r.carry_flag_in; end
                    else
                    begin
                        k = n & (w - 1);
                        res = (k == 0) ? a : (((a >> k) | (a << (w - k))) & m);
                        c = res[w - 1];
                    end
                CMD_RRX:
                begin
                    res = (a >> 1) | (r.carry_flag_in ? sb : 64'd0);
                    c = a[0];
                end
                CMD_ADD, CMD_SUB:
                begin
                    bb  = (r.command == CMD_SUB) ? (~b & m) : b;
                    sum = {1'b0, a} + {1'b0, bb} + 65'(r.carry_flag_in);
                    res = sum[63:0] & m;
                    c   = wide ? sum[64] : sum[32];
                    v   = |(((a ^ res) & (bb ^ res)) & sb);
                end
                CMD_MUL:   res = a * b;
                CMD_UMULH: res = wide ? umul_hi(a, b) : ((a * b) >> 32);
                CMD_SMULH:
                    if (wide)
                    begin
                        res = umul_hi(a, b);
                        if (a[63]) res = res - b;
                        if (b[63]) res = res - a;
                    end
                    else
                    begin
                        sa  = {{32{a[31]}}, a[31:0]};
                        sbv = {{32{b[31]}}, b[31:0]};
                        res = (sa * sbv) >> 32;
                    end
                CMD_UDIV:  res = (b == 0) ? '0 : a / b;
                CMD_SDIV:
                    if (b != 0)
                    begin
                        ma  = a[w - 1] ? ((64'd0 - a) & m) : a;
                        mb  = b[w - 1] ? ((64'd0 - b) & m) : b;
                        q   = ma / mb;
                        res = (a[w - 1] != b[w - 1]) ? (64'd0 - q) : q;
                    end
                CMD_AND:   res = a & b;
                CMD_OR:    res = a | b;
                CMD_EOR:   res = a ^ b;
                CMD_NOT:   res = ~a;
                CMD_CLZ:
                begin
                    cnt = 0;
                    for (int i = w - 1; i >= 0 && !a[i]; i--) cnt++;
                    res = 64'(cnt);
                end
                CMD_REV:
                    for (int i = 0; i < w / 8; i++)
                        res[8 * (w / 8 - 1 - i) +: 8] = a[8 * i +: 8];
                CMD_EXTRACT:
                    if (n == 0) res = a;
                    else if (n < w) res = (a >> n) | ((b << (w - n)) & m);
                    else if (n < 2 * w) res = b >> (n - w);
                CMD_SMAX:  res = ((a ^ sb) > (b ^ sb)) ? a : b;
                CMD_UMAX:  res = (a > b) ? a : b;
                CMD_SMIN:  res = ((a ^ sb) < (b ^ sb)) ? a : b;
                CMD_UMIN:  res = (a < b) ? a : b;
                CMD_SXTB:  res = {{56{a[7]}}, a[7:0]};
                CMD_SXTH:  res = {{48{a[15]}}, a[15:0]};
                CMD_SXTW:  res = {{32{a[31]}}, a[31:0]};
                CMD_TESTBIT:
                begin
                    res  = (n < w) ? 64'(a[n]) : 64'd0;
                    tbit = 1'b1;
                end
                default:   nz_ok = 1'b0;
            endcase
            res = res & m;
            o.result_value   = res;
            o.negative_flag  = nz_ok && !tbit && res[w - 1];
            o.zero_flag      = nz_ok && (res == 0);
            o.carry_flag_out = c;
            o.overflow_flag  = v;
            return o;
        endfunction

        function void note_item(req_t r);
            pending.push_back(compute_alu(r));
        endfunction

        task check_result(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result", got.result_value, 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got.result_value !== want.result_value)
                report("result", got.result_value, want.result_value);
            if (got.negative_flag !== want.negative_flag)
                report("N", 64'(got.negative_flag), 64'(want.negative_flag));
            if (got.zero_flag !== want.zero_flag)
                report("Z", 64'(got.zero_flag), 64'(want.zero_flag));
            if (got.carry_flag_out !== want.carry_flag_out)
                report("C", 64'(got.carry_flag_out), 64'(want.carry_flag_out));
            if (got.overflow_flag !== want.overflow_flag)
                report("V", 64'(got.overflow_flag), 64'(want.overflow_flag));
            n_checked++;
        endtask
    endclass

    alu_scoreboard expected_results;

    // Clock: period 4
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Monitor both handshakes at the edge; sample before any new drive lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                expected_results.note_item(req);
            if (rsp_valid && !rsp_stall)
                expected_results.check_result(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                wdog = 0;
            else
                wdog++;
            if (wdog >= WDOG_MAX)
            begin
                $display("watchdog: no handshake for %0d cycles", WDOG_MAX);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Result side: stall in random bursts of random length, with free stretches
    initial
    begin
        int burst;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (burst > 0)
            begin
                burst--;
                rsp_stall <= (burst > 0);
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 9);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Pick an operand with a bias toward edge values of the given width
    function automatic logic [63:0] pick_operand(logic wide);
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = wide ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
            3: v = wide ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF;
            4: v = 64'($urandom_range(0, 3));
            5: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // Drive one item; hold it until accepted, optionally idle first
    task automatic send_item(input req_t r, input bit may_idle);
        int gap;
        if (may_idle && !quiet_phase && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 9);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        n_sent++;
    endtask

    function automatic req_t make_item(logic [4:0] c, logic wd, logic [63:0] a, logic [63:0] b,
                                       logic [7:0] n, logic ci);
        req_t r;
        r.command       = c;
        r.double_width  = wd;
        r.operand_a     = a;
        r.operand_b     = b;
        r.shift_amount  = n;
        r.carry_flag_in = ci;
        return r;
    endfunction

    function automatic req_t random_item();
        req_t r;
        r.command      = ($urandom_range(0, 49) == 0) ? 5'($urandom_range(27, 31))
                                                      : 5'($urandom_range(0, 26));
        r.double_width = 1'($urandom_range(0, 1));
        r.operand_a    = pick_operand(r.double_width);
        r.operand_b    = pick_operand(r.double_width);
        case ($urandom_range(0, 5))
            0: r.shift_amount = 8'd0;
            1: r.shift_amount = r.double_width ? 8'd64 : 8'd32;
            2: r.shift_amount = 8'($urandom_range(0, 255));
            default: r.shift_amount = 8'($urandom_range(0, r.double_width ? 130 : 66));
        endcase
        r.carry_flag_in = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Wait until every predicted result has come out
    task automatic drain();
        req_valid <= 1'b0;
        while (expected_results.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        expected_results = new();
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        err_count   = 0;
        wdog        = 0;
        n_sent      = 0;
        n_checked   = 0;
        quiet_phase = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero and long shifts, carry in, overflow, division rules,
        // CLZ of zero, extract bounds, test bit past the width, unused command
        send_item(make_item(CMD_LSL, 1'b0, 64'hFFFF_FFFF_8000_0001, '0, 8'd0, 1'b1), 1'b0);
        send_item(make_item(CMD_LSL, 1'b0, 64'h1, '0, 8'd32, 1'b0), 1'b0);
        send_item(make_item(CMD_LSR, 1'b1, '1, '0, 8'd64, 1'b0), 1'b0);
        send_item(make_item(CMD_LSR, 1'b1, '1, '0, 8'd255, 1'b1), 1'b0);
        send_item(make_item(CMD_ASR, 1'b0, 64'h8000_0000, '0, 8'd200, 1'b0), 1'b0);
        send_item(make_item(CMD_ROR, 1'b1, 64'h8000_0000_0000_0001, '0, 8'd128, 1'b0), 1'b0);
        send_item(make_item(CMD_RRX, 1'b1, 64'h1, '0, 8'd0, 1'b1), 1'b0);
        send_item(make_item(CMD_ADD, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 8'd0, 1'b1), 1'b0);
        send_item(make_item(CMD_ADD, 1'b0, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 8'd0, 1'b1), 1'b0);
        send_item(make_item(CMD_SUB, 1'b0, 64'h0, 64'h1, 8'd0, 1'b1), 1'b0);
        send_item(make_item(CMD_SUB, 1'b1, 64'h5, 64'h5, 8'd0, 1'b1), 1'b0);
        send_item(make_item(CMD_SMULH, 1'b1, '1, 64'h8000_0000_0000_0000, 8'd0, 1'b0), 1'b0);
        send_item(make_item(CMD_UMULH, 1'b0, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 8'd0, 1'b0), 1'b0);
        send_item(make_item(CMD_UDIV, 1'b1, 64'h1234, 64'h0, 8'd0, 1'b0), 1'b0);
        send_item(make_item(CMD_SDIV, 1'b1, 64'h8000_0000_0000_0000, '1, 8'd0, 1'b0), 1'b0);
        send_item(make_item(CMD_SDIV, 1'b0, 64'h8000_0000, 64'hFFFF_FFFF, 8'd0, 1'b0), 1'b0);
        send_item(make_item(CMD_SDIV, 1'b0, 64'hFFFF_FFF9, 64'h2, 8'd0, 1'b0), 1'b0);
        send_item(make_item(CMD_CLZ, 1'b1, 64'h0, '0, 8'd0, 1'b0), 1'b0);
        send_item(make_item(CMD_REV, 1'b0, 64'h0102_0304_0506_0708, '0, 8'd0, 1'b0), 1'b0);
        send_item(make_item(CMD_EXTRACT, 1'b0, 64'hAAAA_5555, 64'h1234_5678, 8'd40, 1'b0), 1'b0);
        send_item(make_item(CMD_EXTRACT, 1'b1, '1, '1, 8'd128, 1'b0), 1'b0);
        send_item(make_item(CMD_SXTW, 1'b0, 64'hFFFF_FFFF_8000_0000, '0, 8'd0, 1'b0), 1'b0);
        send_item(make_item(CMD_TESTBIT, 1'b0, '1, '0, 8'd32, 1'b0), 1'b0);
        send_item(make_item(CMD_TESTBIT, 1'b1, '1, '1, 8'd63, 1'b1), 1'b0);
        send_item(make_item(5'd31, 1'b1, '1, '1, 8'hFF, 1'b1), 1'b0);

        // Pause the sender until the pipeline has fully emptied
        drain();

        // Random part; the last stretch runs with no idling on either side
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - 150) quiet_phase = 1'b1;
            if (i == N_RANDOM / 2) drain();
            send_item(random_item(), 1'b1);
        end
        drain();
        repeat (LATENCY + 10) @(posedge clk);

        $display("sent %0d items, checked %0d results", n_sent, n_checked);
        $display("all 27 commands plus unused codes, both widths, corner shifts and divides");
        if (err_count == 0 && expected_results.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ integer_alu_with_flags.f @@
hdl/ial_pkg.sv
hdl/ial_front.sv
hdl/ial_cell.sv
hdl/ial_back.sv
hdl/integer_alu_with_flags.sv
tb/tb.sv
